@@ rtl/hsg_pkg.sv @@
package hsg_pkg;

    typedef struct packed {
        logic               pose_valid;
        logic signed [15:0] hand_x;
        logic signed [15:0] hand_y;
        logic signed [15:0] hand_z;
        logic signed [15:0] head_x;
        logic signed [15:0] head_y;
        logic signed [15:0] head_z;
        logic [31:0]        time_ms;
        logic               gate_blocked;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       trigger_active;
        logic       is_armed;
    } t_out_item;

    typedef struct packed {
        logic        enable;
        logic [12:0] speed_threshold;
        logic [12:0] rearm_speed;
        logic [8:0]  outward_fraction;
        logic [14:0] travel_min;
        logic [15:0] delay_ms;
        logic [15:0] pulse_ms;
        logic [15:0] cooldown_ms;
    } t_cfg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTWARD_FRACTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS      = 3'd7;

    // sample classes found at capture
    typedef enum logic [1:0] {
        CLS_DIS,
        CLS_NOPOSE,
        CLS_RESYNC,
        CLS_MEAS
    } t_cls;

    // multiplier schedule, issued in this order
    typedef enum logic [4:0] {
        OP_D0, OP_D1, OP_D2,
        OP_R0, OP_R1, OP_R2,
        OP_O0, OP_O1, OP_O2,
        OP_T0, OP_T1, OP_T2,
        OP_DT, OP_TS, OP_RS, OP_TM,
        OP_KA, OP_LS, OP_FS, OP_SS,
        OP_KB, OP_AA, OP_KK,
        OP_AH, OP_AM, OP_AL,
        OP_RKH, OP_RKL
    } t_op;

    typedef struct packed {
        logic capture;
        logic eval;
        logic op_valid;
        t_op  op;
        logic decide;
        logic stop_upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
    } t_sts;

endpackage

@@ rtl/hsg_stream_if.sv @@
interface hsg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/hsg_ctrl.sv @@
module hsg_ctrl
    import hsg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_RUN    = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_STOP   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.cls == CLS_MEAS) begin
                    n_state = S_RUN;
                    n_op    = OP_D0;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RUN: begin
                o_cmd.op_valid = 1'b1;
                if (r_op == OP_RKL) begin
                    n_state = S_DRAIN;
                end else begin
                    n_op = t_op'(r_op + 5'd1);
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_STOP;
            end
            S_STOP: begin
                o_cmd.stop_upd = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_D0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken transaction");
    a_capture_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EVAL))
        else $error("capture not followed by evaluation");
    a_op_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_op != OP_RKL) |=>
            (r_state == S_RUN && r_op == $past(r_op) + 5'd1))
        else $error("multiplier schedule skipped a step");
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");
`endif

endmodule

@@ rtl/hsg_datapath.sv @@
module hsg_datapath
    import hsg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_res
);

    localparam logic [1:0]  ST_NONE   = 2'd0;
    localparam logic [1:0]  ST_RESYNC = 2'd1;
    localparam logic [1:0]  ST_MEAS   = 2'd2;
    localparam logic [1:0]  ST_FIRED  = 2'd3;
    localparam logic [31:0] GAP_LIMIT = 32'd250;
    localparam logic [15:0] MIN_PULSE = 16'd20;
    localparam logic [35:0] SPEED_K   = 36'd15625;
    localparam logic [35:0] DIR_K     = 36'd16000;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)       r = 16'sh7fff;
        else if (v < -17'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    // persistent state
    logic signed [15:0] r_prev [3];
    logic signed [15:0] r_rest [3];
    logic               r_prev_valid, r_rest_valid, r_armed, r_sched, r_fired;
    logic [31:0]        r_prev_time, r_cool_end, r_pstart, r_pstop;

    // captured sample
    logic signed [15:0] r_rel [3];
    logic signed [16:0] r_d [3];
    logic signed [16:0] r_t [3];
    logic [7:0]         r_dt;
    logic [31:0]        r_now;
    logic               r_gate;
    t_cls               r_cls;
    logic [1:0]         r_status;

    // products and sums
    logic signed [71:0] r_prod;
    t_op                r_acc_op;
    logic               r_acc_valid;
    logic [34:0]        r_d2, r_t2;
    logic [31:0]        r_r2;
    logic signed [33:0] r_dot;
    logic [15:0]        r_dtsq;
    logic [25:0]        r_tsq, r_rsq;
    logic [29:0]        r_tmsq, r_k;
    logic [20:0]        r_k1;
    logic [48:0]        r_lhs;
    logic [43:0]        r_fast, r_slow;
    logic [46:0]        r_a;
    logic [59:0]        r_ksq;
    logic [95:0]        r_left, r_right;

    t_out_item r_res;

    logic signed [15:0] c_rel [3];
    logic [31:0]        c_dt;
    t_cls               c_cls;
    logic signed [35:0] m_a, m_b;
    logic               c_slow, c_fast, c_dir, c_travel, c_fire;
    logic [34:0]        c_t2;
    logic [31:0]        c_pstart;
    logic [15:0]        c_len;

    always_comb begin
        c_rel[0] = sat16(17'(i_item.hand_x) - 17'(i_item.head_x));
        c_rel[1] = sat16(17'(i_item.hand_y) - 17'(i_item.head_y));
        c_rel[2] = sat16(17'(i_item.hand_z) - 17'(i_item.head_z));
        c_dt     = i_item.time_ms - r_prev_time;
        if (!i_cfg.enable)                                        c_cls = CLS_DIS;
        else if (!i_item.pose_valid)                              c_cls = CLS_NOPOSE;
        else if (!r_prev_valid || c_dt == '0 || c_dt > GAP_LIMIT) c_cls = CLS_RESYNC;
        else                                                      c_cls = CLS_MEAS;
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_D0:  begin m_a = 36'(r_d[0]);   m_b = 36'(r_d[0]);   end
            OP_D1:  begin m_a = 36'(r_d[1]);   m_b = 36'(r_d[1]);   end
            OP_D2:  begin m_a = 36'(r_d[2]);   m_b = 36'(r_d[2]);   end
            OP_R0:  begin m_a = 36'(r_rel[0]); m_b = 36'(r_rel[0]); end
            OP_R1:  begin m_a = 36'(r_rel[1]); m_b = 36'(r_rel[1]); end
            OP_R2:  begin m_a = 36'(r_rel[2]); m_b = 36'(r_rel[2]); end
            OP_O0:  begin m_a = 36'(r_d[0]);   m_b = 36'(r_rel[0]); end
            OP_O1:  begin m_a = 36'(r_d[1]);   m_b = 36'(r_rel[1]); end
            OP_O2:  begin m_a = 36'(r_d[2]);   m_b = 36'(r_rel[2]); end
            OP_T0:  begin m_a = 36'(r_t[0]);   m_b = 36'(r_t[0]);   end
            OP_T1:  begin m_a = 36'(r_t[1]);   m_b = 36'(r_t[1]);   end
            OP_T2:  begin m_a = 36'(r_t[2]);   m_b = 36'(r_t[2]);   end
            OP_DT:  begin m_a = 36'(r_dt);     m_b = 36'(r_dt);     end
            OP_TS:  begin
                m_a = 36'(i_cfg.speed_threshold);
                m_b = 36'(i_cfg.speed_threshold);
            end
            OP_RS:  begin
                m_a = 36'(i_cfg.rearm_speed);
                m_b = 36'(i_cfg.rearm_speed);
            end
            OP_TM:  begin
                m_a = 36'(i_cfg.travel_min);
                m_b = 36'(i_cfg.travel_min);
            end
            OP_KA:  begin m_a = 36'(r_dt);   m_b = 36'(i_cfg.speed_threshold); end
            OP_LS:  begin m_a = 36'(r_d2);   m_b = SPEED_K; end
            OP_FS:  begin m_a = 36'({r_dtsq, 2'b00}); m_b = 36'(r_tsq); end
            OP_SS:  begin m_a = 36'({r_dtsq, 2'b00}); m_b = 36'(r_rsq); end
            OP_KB:  begin m_a = 36'(r_k1);   m_b = 36'(i_cfg.outward_fraction); end
            OP_AA:  begin m_a = 36'(r_dot);  m_b = DIR_K; end
            OP_KK:  begin m_a = 36'(r_k);    m_b = 36'(r_k); end
            OP_AH:  begin m_a = 36'(r_a[46:24]); m_b = 36'(r_a[46:24]); end
            OP_AM:  begin m_a = 36'(r_a[46:24]); m_b = 36'(r_a[23:0]);  end
            OP_AL:  begin m_a = 36'(r_a[23:0]);  m_b = 36'(r_a[23:0]);  end
            OP_RKH: begin m_a = 36'(r_r2);   m_b = 36'(r_ksq[59:30]); end
            OP_RKL: begin m_a = 36'(r_r2);   m_b = 36'(r_ksq[29:0]);  end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    // products: one registered multiply, summed in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod   <= m_a * m_b;
        r_acc_op <= i_cmd.op;
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else begin
            r_acc_valid <= i_cmd.op_valid;
        end
        if (r_acc_valid) begin
            case (r_acc_op)
                OP_D0:  r_d2   <= r_prod[34:0];
                OP_D1,
                OP_D2:  r_d2   <= r_d2 + r_prod[34:0];
                OP_R0:  r_r2   <= r_prod[31:0];
                OP_R1,
                OP_R2:  r_r2   <= r_r2 + r_prod[31:0];
                OP_O0:  r_dot  <= r_prod[33:0];
                OP_O1,
                OP_O2:  r_dot  <= r_dot + r_prod[33:0];
                OP_T0:  r_t2   <= r_prod[34:0];
                OP_T1,
                OP_T2:  r_t2   <= r_t2 + r_prod[34:0];
                OP_DT:  r_dtsq <= r_prod[15:0];
                OP_TS:  r_tsq  <= r_prod[25:0];
                OP_RS:  r_rsq  <= r_prod[25:0];
                OP_TM:  r_tmsq <= r_prod[29:0];
                OP_KA:  r_k1   <= r_prod[20:0];
                OP_LS:  r_lhs  <= r_prod[48:0];
                OP_FS:  r_fast <= r_prod[43:0];
                OP_SS:  r_slow <= r_prod[43:0];
                OP_KB:  r_k    <= r_prod[29:0];
                OP_AA:  r_a    <= r_prod[46:0];
                OP_KK:  r_ksq  <= r_prod[59:0];
                OP_AH:  r_left <= {2'b00, r_prod[45:0], 48'b0};
                OP_AM:  r_left <= r_left + {24'b0, r_prod[46:0], 25'b0};
                OP_AL:  r_left <= r_left + {48'b0, r_prod[47:0]};
                OP_RKH: r_right <= {4'b0, r_prod[61:0], 30'b0};
                OP_RKL: r_right <= r_right + {34'b0, r_prod[61:0]};
                default: ;
            endcase
        end
    end

    always_comb begin
        c_slow   = {5'b0, r_slow} >= r_lhs;
        c_fast   = r_lhs >= {5'b0, r_fast};
        if (r_r2 == '0)      c_dir = (r_k == '0);
        else if (r_dot < 0)  c_dir = 1'b0;
        else                 c_dir = (r_left >= r_right);
        // re-arming moves the rest point onto this sample, so travel is zero
        c_t2     = (c_slow || !r_rest_valid) ? '0 : r_t2;
        c_travel = c_t2 >= {5'b0, r_tmsq};
        c_fire   = !r_gate && (r_armed || c_slow) && c_fast && c_dir && c_travel &&
                   (r_now >= r_cool_end);
        c_pstart = sat_add32(r_now, {16'b0, i_cfg.delay_ms});
        c_len    = (i_cfg.pulse_ms < MIN_PULSE) ? MIN_PULSE : i_cfg.pulse_ms;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < 3; i++) begin
                r_rel[i] <= c_rel[i];
                r_d[i]   <= 17'(c_rel[i]) - 17'(r_prev[i]);
                r_t[i]   <= 17'(c_rel[i]) - 17'(r_rest[i]);
            end
            r_dt   <= c_dt[7:0];
            r_now  <= i_item.time_ms;
            r_gate <= i_item.gate_blocked;
            r_cls  <= c_cls;
        end
        if (i_cmd.load_out) begin
            r_res.status         <= r_status;
            r_res.trigger_active <= r_sched && (r_now >= r_pstart) && (r_now < r_pstop);
            r_res.is_armed       <= r_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
                r_rest[i] <= '0;
            end
            r_prev_valid <= 1'b0;
            r_rest_valid <= 1'b0;
            r_armed      <= 1'b1;
            r_sched      <= 1'b0;
            r_fired      <= 1'b0;
            r_prev_time  <= '0;
            r_cool_end   <= '0;
            r_pstart     <= '0;
            r_pstop      <= '0;
            r_status     <= ST_NONE;
        end else begin
            if (i_cmd.eval) begin
                case (r_cls)
                    CLS_DIS: begin
                        r_prev_valid <= 1'b0;
                        r_armed      <= 1'b1;
                        r_sched      <= 1'b0;
                        r_pstart     <= '0;
                        r_pstop      <= '0;
                        r_status     <= ST_NONE;
                    end
                    CLS_NOPOSE: begin
                        r_prev_valid <= 1'b0;
                        r_status     <= ST_NONE;
                    end
                    CLS_RESYNC: begin
                        for (int i = 0; i < 3; i++) r_prev[i] <= r_rel[i];
                        r_prev_time  <= r_now;
                        r_prev_valid <= 1'b1;
                        r_status     <= ST_RESYNC;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.decide) begin
                for (int i = 0; i < 3; i++) r_prev[i] <= r_rel[i];
                r_prev_time <= r_now;
                if (c_slow) begin
                    for (int i = 0; i < 3; i++) r_rest[i] <= r_rel[i];
                    r_rest_valid <= 1'b1;
                end
                r_fired <= c_fire;
                if (c_fire) begin
                    r_armed    <= 1'b0;
                    r_pstart   <= c_pstart;
                    r_sched    <= 1'b1;
                    r_cool_end <= sat_add32(r_now, {16'b0, i_cfg.cooldown_ms});
                    r_status   <= ST_FIRED;
                end else begin
                    if (c_slow) r_armed <= 1'b1;
                    r_status <= ST_MEAS;
                end
            end
            if (i_cmd.stop_upd && r_fired) begin
                r_pstop <= sat_add32(r_pstart, {16'b0, c_len});
            end
        end
    end

    assign o_sts.cls = r_cls;
    assign o_res     = r_res;

endmodule

@@ rtl/hand_swing_gesture_detector_top.sv @@
// Channel  Dir  Payload     Handshake
// i_in     in   t_in_item   valid/ready, transaction when both high
// o_out    out  t_out_item  valid/ready, transaction when both high
// i_cfg_*  in   16-bit data write enable, index selects the register
//
// One sample at a time. Disabled, untracked and resync samples go through capture,
// evaluation and output load. Measured samples go through capture, evaluation,
// 28 serial passes through the one shared 36x36 multiplier, drain, decision,
// pulse end and output load. The result is registered valid at output load. Input
// is ready only when idle; a held result does not stop the next sample being
// taken, but that sample stalls at output load until the held transaction goes.
// Synchronous active-low reset.
module hand_swing_gesture_detector_top
    import hsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hsg_stream_if.sink            i_in,
    hsg_stream_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_cmd      w_cmd;
    t_sts      w_sts;
    t_out_item w_res;
    logic      w_in_ready, w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b1;
            r_cfg.speed_threshold  <= 13'd640;
            r_cfg.rearm_speed      <= 13'd256;
            r_cfg.outward_fraction <= 9'd128;
            r_cfg.travel_min       <= 15'd614;
            r_cfg.delay_ms         <= 16'd0;
            r_cfg.pulse_ms         <= 16'd120;
            r_cfg.cooldown_ms      <= 16'd400;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:           r_cfg.enable           <= i_cfg_data[0];
                CFG_SPEED_THRESHOLD:  r_cfg.speed_threshold  <= i_cfg_data[12:0];
                CFG_REARM_SPEED:      r_cfg.rearm_speed      <= i_cfg_data[12:0];
                CFG_OUTWARD_FRACTION: r_cfg.outward_fraction <= i_cfg_data[8:0];
                CFG_TRAVEL_MIN:       r_cfg.travel_min       <= i_cfg_data[14:0];
                CFG_DELAY_MS:         r_cfg.delay_ms         <= i_cfg_data;
                CFG_PULSE_MS:         r_cfg.pulse_ms         <= i_cfg_data;
                CFG_COOLDOWN_MS:      r_cfg.cooldown_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hsg_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_in.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_res;

endmodule
